[rtl/core/bscs_pkg.sv]
// ----------------------------------------------------------------------------
// Scene sequencer package
// Shared sizes, mode codes and the input word type for the scene sequencer.
// ----------------------------------------------------------------------------
package bscs_pkg;

    // Table sizes
    localparam int MAX_SCENES      = 16;
    localparam int MAX_TRACKS      = 8;
    localparam int MAX_CHAIN_STEPS = 16;

    // Field widths
    localparam int MODE_W   = 3;
    localparam int SCENE_W  = 4;
    localparam int TRACK_W  = 3;
    localparam int BANK_W   = 8;
    localparam int STEP_W   = 4;
    localparam int REPEAT_W = 8;
    localparam int LEN_W    = 5;

    // Derived storage sizes
    localparam int BANK_DEPTH = MAX_SCENES * MAX_TRACKS;
    localparam int ADDR_W     = $clog2(BANK_DEPTH);
    localparam int SIU_W      = $clog2(MAX_SCENES + 1);
    localparam int BAR_W      = 8;
    localparam logic [BAR_W-1:0] BAR_MAX = '1;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_WRITE_BANK = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE_STEP = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET_CHAIN  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QUEUE      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_APPLY_NOW  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_START      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BAR        = 3'd6;
    localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd7;

    // One input word, split into its fields
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [SCENE_W-1:0]  scene_index;
        logic [TRACK_W-1:0]  track_index;
        logic [BANK_W-1:0]   bank_value;
        logic [STEP_W-1:0]   step_index;
        logic [REPEAT_W-1:0] repeat_bars;
        logic [LEN_W-1:0]    chain_len;
        logic                loop_enable;
    } item_t;

endpackage

[rtl/core/bscs_scene_store.sv]
// ----------------------------------------------------------------------------
// Scene store
// Bank index memory with per-entry valid bits, scene valid bits, scene count
// and the registered bank query result.
// ----------------------------------------------------------------------------
module bscs_scene_store (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 go,
    input  bscs_pkg::item_t                      item,
    input  logic [bscs_pkg::SCENE_W-1:0]         active_scene,
    output logic [bscs_pkg::MAX_SCENES-1:0]      scene_valid,
    output logic [bscs_pkg::BANK_W-1:0]          bank_q
);
    import bscs_pkg::*;

    logic [BANK_W-1:0]     bank_mem [BANK_DEPTH];
    logic [BANK_DEPTH-1:0] entry_valid_reg;
    logic [MAX_SCENES-1:0] scene_valid_reg;
    logic [SIU_W-1:0]      siu_reg;
    logic [SIU_W-1:0]      siu_next;
    logic [BANK_W-1:0]     rd_data_reg;
    logic                  hit_reg;
    logic                  hit_next;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;

    assign scene_valid = scene_valid_reg;

    // Write and query decode
    always_comb
    begin
        wr_en   = go && (item.mode == MODE_WRITE_BANK)
                  && (int'(item.scene_index) < MAX_SCENES)
                  && (int'(item.track_index) < MAX_TRACKS);
        wr_addr = ADDR_W'(int'(item.scene_index) * MAX_TRACKS + int'(item.track_index));
        rd_addr = ADDR_W'(int'(active_scene) * MAX_TRACKS + int'(item.track_index));
        siu_next = siu_reg;
        if (wr_en && (SIU_W'(item.scene_index) >= siu_reg))
        begin
            siu_next = SIU_W'(item.scene_index) + SIU_W'(1);
        end
        hit_next = (item.mode == MODE_QUERY)
                   && (int'(item.track_index) < MAX_TRACKS)
                   && (SIU_W'(active_scene) < siu_reg)
                   && scene_valid_reg[active_scene]
                   && entry_valid_reg[rd_addr];
    end

    // Bank memory: one write and one registered read per cycle, both only on go
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bank_mem[wr_addr] <= item.bank_value;
        end
        if (go)
        begin
            rd_data_reg <= bank_mem[rd_addr];
        end
    end

    // Valid bits, scene count and query hit flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            scene_valid_reg <= '0;
            siu_reg         <= '0;
            hit_reg         <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_valid_reg[wr_addr]           <= 1'b1;
                scene_valid_reg[item.scene_index]  <= 1'b1;
            end
            siu_reg <= siu_next;
            if (go)
            begin
                hit_reg <= hit_next;
            end
        end
    end

    // A query that misses reads as zero
    assign bank_q = hit_reg ? rd_data_reg : '0;

    // The scene count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(siu_reg) <= MAX_SCENES)
        else $error("scene count beyond table size");

    // A bank write marks its scene valid and covers it in the scene count.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> scene_valid_reg[$past(item.scene_index)]
                  && (siu_reg > SIU_W'($past(item.scene_index))))
        else $error("bank write did not mark scene");

endmodule

[rtl/core/bscs_chain_ctrl.sv]
// ----------------------------------------------------------------------------
// Chain controller
// Chain step tables, chain position, bar counter and the active and pending
// scene registers, updated by one input word per cycle while go is high.
// ----------------------------------------------------------------------------
module bscs_chain_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             go,
    input  bscs_pkg::item_t                  item,
    input  logic [bscs_pkg::MAX_SCENES-1:0]  scene_valid,
    output logic [bscs_pkg::SCENE_W-1:0]     active_next
);
    import bscs_pkg::*;

    logic [SCENE_W-1:0]  step_scene_reg  [MAX_CHAIN_STEPS];
    logic [REPEAT_W-1:0] step_repeat_reg [MAX_CHAIN_STEPS];
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    len_next;
    logic                wraps_reg;
    logic                wraps_next;
    logic [STEP_W-1:0]   pos_reg;
    logic [STEP_W-1:0]   pos_next;
    logic [BAR_W-1:0]    bar_reg;
    logic [BAR_W-1:0]    bar_next;
    logic [SCENE_W-1:0]  active_reg;
    logic [SCENE_W-1:0]  pending_reg;
    logic [SCENE_W-1:0]  pending_next;
    logic [BAR_W-1:0]    bar_cnt;
    logic [LEN_W-1:0]    pos_inc;
    logic [SCENE_W-1:0]  next_scene;
    logic                step_wr;

    // Next-state logic for one word
    always_comb
    begin
        len_next     = len_reg;
        wraps_next   = wraps_reg;
        pos_next     = pos_reg;
        bar_next     = bar_reg;
        active_next  = active_reg;
        pending_next = pending_reg;
        bar_cnt      = bar_reg;
        pos_inc      = LEN_W'(pos_reg) + LEN_W'(1);
        next_scene   = '0;
        step_wr      = 1'b0;

        unique case (item.mode)
            MODE_WRITE_BANK,
            MODE_QUERY:
            begin
                // Handled by the scene store
            end
            MODE_WRITE_STEP:
            begin
                step_wr = int'(item.step_index) < MAX_CHAIN_STEPS;
            end
            MODE_SET_CHAIN:
            begin
                len_next   = (item.chain_len > LEN_W'(MAX_CHAIN_STEPS)) ?
                             LEN_W'(MAX_CHAIN_STEPS) : item.chain_len;
                wraps_next = item.loop_enable;
                pos_next   = '0;
                bar_next   = '0;
            end
            MODE_QUEUE:
            begin
                if ((int'(item.scene_index) < MAX_SCENES) && scene_valid[item.scene_index])
                begin
                    pending_next = item.scene_index;
                end
            end
            MODE_APPLY_NOW:
            begin
                if (int'(item.scene_index) < MAX_SCENES)
                begin
                    active_next  = item.scene_index;
                    pending_next = item.scene_index;
                end
            end
            MODE_START:
            begin
                bar_next = '0;
            end
            MODE_BAR:
            begin
                // Pending switch takes effect first and restarts the count.
                if (pending_reg != active_reg)
                begin
                    active_next = pending_reg;
                    bar_cnt     = '0;
                end
                bar_next = bar_cnt;
                if (len_reg != '0)
                begin
                    if (bar_cnt != BAR_MAX)
                    begin
                        bar_cnt = bar_cnt + BAR_W'(1);
                    end
                    bar_next = bar_cnt;
                    // The position always stays below the chain length.
                    if (bar_cnt >= step_repeat_reg[pos_reg])
                    begin
                        bar_next = '0;
                        if (wraps_reg && (pos_inc == len_reg))
                        begin
                            pos_inc = '0;
                        end
                        if (!wraps_reg && (pos_inc >= len_reg))
                        begin
                            pos_next = STEP_W'(len_reg - LEN_W'(1));
                        end
                        else
                        begin
                            pos_next   = STEP_W'(pos_inc);
                            next_scene = step_scene_reg[STEP_W'(pos_inc)];
                            if (scene_valid[next_scene])
                            begin
                                pending_next = next_scene;
                            end
                        end
                    end
                end
            end
        endcase
    end

    // Chain step tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHAIN_STEPS; i++)
            begin
                step_scene_reg[i]  <= '0;
                step_repeat_reg[i] <= '0;
            end
        end
        else if (go && step_wr)
        begin
            step_scene_reg[item.step_index]  <= item.scene_index;
            step_repeat_reg[item.step_index] <= item.repeat_bars;
        end
    end

    // Chain and scene state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            wraps_reg   <= 1'b0;
            pos_reg     <= '0;
            bar_reg     <= '0;
            active_reg  <= '0;
            pending_reg <= '0;
        end
        else if (go)
        begin
            len_reg     <= len_next;
            wraps_reg   <= wraps_next;
            pos_reg     <= pos_next;
            bar_reg     <= bar_next;
            active_reg  <= active_next;
            pending_reg <= pending_next;
        end
    end

    // The chain position stays inside the chain, and at zero with no chain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) ? (LEN_W'(pos_reg) < len_reg) : (pos_reg == '0))
        else $error("chain position outside chain");

    // The chain length never exceeds the step table.
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(len_reg) <= MAX_CHAIN_STEPS)
        else $error("chain length beyond step table");

endmodule

[rtl/core/bar_synced_scene_chain_sequencer.sv]
// ----------------------------------------------------------------------------
// Bar-synced scene chain sequencer
// Top level: input register, scene store, chain controller, result register.
// ----------------------------------------------------------------------------
// Usage:
// Each input word on the s_ channel carries a mode in s_tuser and its operand
// fields in s_tdata. Every accepted word yields exactly one result word on the
// m_ channel: the active scene after the word is handled, and for a bank
// query the bank index of the addressed track of the active scene (zero for
// a track never written, an invalid scene or any other mode).
// An accepted word waits in the input register, then the state update and
// the registered bank memory read land together in the result register.
// Throughput is one word per cycle while the receiver does not stall, set by
// the state update and the single read port of the 128-entry bank memory.
// Reset clears the step tables, valid bits and state registers; the bank
// memory is covered by per-entry valid bits, so no clearing pass is needed
// and s_tready is high right after reset.
// When the receiver stalls, the result is held and the input register fills;
// s_tready drops only while both stages are full.
// ----------------------------------------------------------------------------
module bar_synced_scene_chain_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // scene_index[3:0], track_index[6:4], bank_value[14:7], step_index[18:15],
    // repeat_bars[26:19], chain_len[31:27], loop_enable[32], zero[39:33]
    input  logic [39:0] s_tdata,
    // mode[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // current_scene[3:0], bank_out[11:4], zero[15:12]
    output logic [15:0] m_tdata
);
    import bscs_pkg::*;

    item_t                 in_item_reg;
    logic                  in_valid_reg;
    logic                  out_valid_reg;
    logic [SCENE_W-1:0]    scene_out_reg;
    logic                  advance;
    logic                  go;
    logic [MAX_SCENES-1:0] scene_valid;
    logic [SCENE_W-1:0]    active_next;
    logic [BANK_W-1:0]     bank_q;

    // Pipeline control
    assign advance  = !out_valid_reg || m_tready;
    assign go       = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_item_reg <= '0;
        end
        else if (s_tready && s_tvalid)
        begin
            in_item_reg.mode        <= s_tuser;
            in_item_reg.scene_index <= s_tdata[3:0];
            in_item_reg.track_index <= s_tdata[6:4];
            in_item_reg.bank_value  <= s_tdata[14:7];
            in_item_reg.step_index  <= s_tdata[18:15];
            in_item_reg.repeat_bars <= s_tdata[26:19];
            in_item_reg.chain_len   <= s_tdata[31:27];
            in_item_reg.loop_enable <= s_tdata[32];
        end
    end

    // Scene memory and query
    bscs_scene_store u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (go),
        .item         (in_item_reg),
        .active_scene (active_next),
        .scene_valid  (scene_valid),
        .bank_q       (bank_q)
    );

    // Chain and scene switching
    bscs_chain_ctrl u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .item        (in_item_reg),
        .scene_valid (scene_valid),
        .active_next (active_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            scene_out_reg <= active_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, bank_q, scene_out_reg};

    // A full input register is only blocked by a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !s_tready) |-> (out_valid_reg && !m_tready))
        else $error("input stage blocked without a stalled result");

    // A processed word always shows up as a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        go |=> out_valid_reg)
        else $error("processed word lost");

endmodule

[test/tb_bar_synced_scene_chain_sequencer.sv]
// ----------------------------------------------------------------------------
// Testbench for the bar-synced scene chain sequencer
// Sends directed and random command words with random gaps on the input
// stream and random stalls on the result stream. A behavioral copy of the
// sequencer state predicts every result word, which is checked field by field.
// ----------------------------------------------------------------------------
module tb_bar_synced_scene_chain_sequencer;
    import bscs_pkg::*;

    localparam int RANDOM_WORDS = 1350;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;

    // Expected contents of one result word.
    typedef struct {
        logic [SCENE_W-1:0] scene;
        logic [BANK_W-1:0]  bank;
    } scene_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // Stimulus and expectations.
    item_t         words_to_send[$];
    scene_result_t scene_results_due[$];
    item_t         word_on_bus;
    int            words_total    = 0;
    int            words_accepted = 0;
    int            mismatches     = 0;
    int            idle_cycles    = 0;
    int            src_gap        = 0;
    int            sink_stall     = 0;
    bit            src_calm       = 1'b0;
    bit            sink_calm      = 1'b0;

    // Behavioral copy of the sequencer state.
    logic [BANK_W-1:0]   bank_mem[BANK_DEPTH];
    logic                scene_ok[MAX_SCENES];
    logic [SIU_W-1:0]    scenes_used;
    logic [SCENE_W-1:0]  step_scene[MAX_CHAIN_STEPS];
    logic [REPEAT_W-1:0] step_repeat[MAX_CHAIN_STEPS];
    logic [LEN_W-1:0]    chain_len_q;
    logic                chain_loops;
    logic [STEP_W-1:0]   chain_pos;
    logic [BAR_W-1:0]    bars_counted;
    logic [SCENE_W-1:0]  active_scene;
    logic [SCENE_W-1:0]  pending_scene;

    bar_synced_scene_chain_sequencer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // A queued scene only takes hold if it has been written.
    function automatic void queue_if_valid(logic [SCENE_W-1:0] scene);
        if (scene_ok[scene])
        begin
            pending_scene = scene;
        end
    endfunction

    // Apply one accepted command word to the state copy and queue its result.
    function automatic void update_scene_state(item_t w);
        logic [BANK_W-1:0] bank_res;
        int                slot;
        int                next_pos;
        scene_result_t     res;
        bank_res = '0;
        case (w.mode)
            MODE_WRITE_BANK:
            begin
                bank_mem[int'(w.scene_index) * MAX_TRACKS + int'(w.track_index)] = w.bank_value;
                scene_ok[w.scene_index] = 1'b1;
                if (SIU_W'(w.scene_index) >= scenes_used)
                begin
                    scenes_used = SIU_W'(w.scene_index) + 1'b1;
                end
            end
            MODE_WRITE_STEP:
            begin
                step_scene[w.step_index]  = w.scene_index;
                step_repeat[w.step_index] = w.repeat_bars;
            end
            MODE_SET_CHAIN:
            begin
                chain_len_q  = (w.chain_len > MAX_CHAIN_STEPS) ? LEN_W'(MAX_CHAIN_STEPS)
                                                               : w.chain_len;
                chain_loops  = w.loop_enable;
                chain_pos    = '0;
                bars_counted = '0;
            end
            MODE_QUEUE:
            begin
                queue_if_valid(w.scene_index);
            end
            MODE_APPLY_NOW:
            begin
                active_scene  = w.scene_index;
                pending_scene = w.scene_index;
            end
            MODE_START:
            begin
                bars_counted = '0;
            end
            MODE_BAR:
            begin
                // A pending switch lands first and restarts the bar count.
                if (pending_scene != active_scene)
                begin
                    active_scene = pending_scene;
                    bars_counted = '0;
                end
                if (chain_len_q != 0)
                begin
                    if (bars_counted != BAR_MAX)
                    begin
                        bars_counted = bars_counted + 1'b1;
                    end
                    slot = (int'(chain_pos) % int'(chain_len_q)) % MAX_CHAIN_STEPS;
                    if (bars_counted >= step_repeat[slot])
                    begin
                        // Step done: wrap or hold on the last step.
                        bars_counted = '0;
                        next_pos = int'(chain_pos) + 1;
                        if (chain_loops)
                        begin
                            next_pos = next_pos % int'(chain_len_q);
                        end
                        if (!chain_loops && next_pos >= int'(chain_len_q))
                        begin
                            chain_pos = STEP_W'(chain_len_q - 1'b1);
                        end
                        else
                        begin
                            chain_pos = STEP_W'(next_pos);
                            queue_if_valid(step_scene[next_pos % MAX_CHAIN_STEPS]);
                        end
                    end
                end
            end
            MODE_QUERY:
            begin
                if (SIU_W'(active_scene) < scenes_used && scene_ok[active_scene])
                begin
                    bank_res = bank_mem[int'(active_scene) * MAX_TRACKS
                                        + int'(w.track_index)];
                end
            end
            default:
            begin
            end
        endcase
        res.scene = active_scene;
        res.bank  = bank_res;
        scene_results_due.push_back(res);
    endfunction

    // Mostly short gaps, a few long ones, none while calm.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // A word with every field random; callers override what matters.
    function automatic item_t rand_word(logic [MODE_W-1:0] mode);
        item_t w;
        w.mode        = mode;
        w.scene_index = SCENE_W'($urandom);
        w.track_index = TRACK_W'($urandom);
        w.bank_value  = BANK_W'($urandom);
        w.step_index  = STEP_W'($urandom);
        w.repeat_bars = REPEAT_W'($urandom);
        w.chain_len   = LEN_W'($urandom);
        w.loop_enable = 1'($urandom);
        return w;
    endfunction

    function automatic void push_bank_write(int scene, int track, int bank);
        item_t w;
        w             = rand_word(MODE_WRITE_BANK);
        w.scene_index = SCENE_W'(scene);
        w.track_index = TRACK_W'(track);
        w.bank_value  = BANK_W'(bank);
        words_to_send.push_back(w);
    endfunction

    function automatic void push_step_write(int step, int scene, int bars);
        item_t w;
        w             = rand_word(MODE_WRITE_STEP);
        w.step_index  = STEP_W'(step);
        w.scene_index = SCENE_W'(scene);
        w.repeat_bars = REPEAT_W'(bars);
        words_to_send.push_back(w);
    endfunction

    function automatic void push_chain(int len, int loops);
        item_t w;
        w             = rand_word(MODE_SET_CHAIN);
        w.chain_len   = LEN_W'(len);
        w.loop_enable = 1'(loops);
        words_to_send.push_back(w);
    endfunction

    // Queue, apply, start, bar and query words: scene and track operands.
    function automatic void push_op(logic [MODE_W-1:0] mode, int scene, int track);
        item_t w;
        w             = rand_word(mode);
        w.scene_index = SCENE_W'(scene);
        w.track_index = TRACK_W'(track);
        words_to_send.push_back(w);
    endfunction

    function automatic void report_mismatch(string field, int want, int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endfunction

    // Input driver: predicts each accepted word, then presents the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                update_scene_state(word_on_bus);
                words_accepted++;
            end
            if ($urandom_range(0, 199) == 0)
            begin
                src_calm = !src_calm;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (words_to_send.size() > 0)
                begin
                    word_on_bus = words_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, word_on_bus.loop_enable, word_on_bus.chain_len,
                                 word_on_bus.repeat_bars, word_on_bus.step_index,
                                 word_on_bus.bank_value, word_on_bus.track_index,
                                 word_on_bus.scene_index};
                    s_tuser  <= word_on_bus.mode;
                    src_gap = pick_gap(src_calm);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random backpressure.
    always @(posedge clk)
    begin
        scene_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (scene_results_due.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = scene_results_due.pop_front();
                    if (m_tdata[3:0] !== want.scene)
                    begin
                        report_mismatch("current_scene", want.scene, m_tdata[3:0]);
                    end
                    if (m_tdata[11:4] !== want.bank)
                    begin
                        report_mismatch("bank_out", want.bank, m_tdata[11:4]);
                    end
                    if (m_tdata[15:12] !== 4'b0)
                    begin
                        report_mismatch("padding", 0, m_tdata[15:12]);
                    end
                end
            end
            if ($urandom_range(0, 199) == 0)
            begin
                sink_calm = !sink_calm;
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                begin
                    sink_stall = pick_gap(sink_calm);
                end
            end
        end
    end

    // Watchdog: cycles in which neither stream moves a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
    end

    initial
    begin
        int  r;
        int  n_steps;
        int  directed_words;
        bit  hold_done;
        hold_done = 1'b0;

        // Clear the state copy to its reset values.
        foreach (bank_mem[i]) bank_mem[i] = '0;
        foreach (scene_ok[i]) scene_ok[i] = 1'b0;
        foreach (step_scene[i])
        begin
            step_scene[i]  = '0;
            step_repeat[i] = '0;
        end
        scenes_used   = '0;
        chain_len_q   = '0;
        chain_loops   = 1'b0;
        chain_pos     = '0;
        bars_counted  = '0;
        active_scene  = '0;
        pending_scene = '0;

        // Directed: reset state, invalid scenes, queue and apply, chains.
        push_op(MODE_QUERY, 0, 0);
        push_op(MODE_BAR, 0, 0);
        push_bank_write(0, 0, 255);
        push_bank_write(5, 3, 165);
        push_op(MODE_QUERY, 0, 0);
        push_op(MODE_QUEUE, 9, 0);
        push_op(MODE_BAR, 0, 0);
        // Active scene beyond the scene count, then invalid below it.
        push_op(MODE_APPLY_NOW, 9, 0);
        push_op(MODE_QUERY, 0, 3);
        push_op(MODE_APPLY_NOW, 3, 0);
        push_op(MODE_QUERY, 0, 3);
        push_bank_write(15, 7, 0);
        push_op(MODE_QUEUE, 15, 0);
        push_op(MODE_BAR, 0, 0);
        push_op(MODE_QUERY, 0, 7);
        push_op(MODE_APPLY_NOW, 5, 0);
        push_op(MODE_QUERY, 0, 3);
        push_step_write(0, 0, 0);
        push_step_write(1, 5, 2);
        push_step_write(15, 15, 255);
        // Looping chain, then a chain that holds its last step.
        push_chain(2, 1);
        repeat (4) push_op(MODE_BAR, 0, 0);
        push_chain(2, 0);
        repeat (3) push_op(MODE_BAR, 0, 0);
        push_op(MODE_START, 0, 0);
        // Oversized chain length saturates; length zero disables.
        push_chain(31, 0);
        repeat (2) push_op(MODE_BAR, 0, 0);
        push_chain(0, 1);
        push_op(MODE_BAR, 0, 0);
        directed_words = words_to_send.size();

        // Random: mostly well-formed chain runs, the rest noise.
        while (words_to_send.size() < directed_words + RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (!hold_done && words_to_send.size() > 700)
            begin
                // One step held for a repeat count from 250 to 255.
                hold_done = 1'b1;
                push_bank_write($urandom_range(0, 15), $urandom_range(0, 7), $urandom);
                push_step_write(0, $urandom_range(0, 15), $urandom_range(250, 255));
                push_chain(1, 1);
                repeat (260)
                begin
                    if ($urandom_range(0, 9) == 0)
                        push_op(MODE_QUERY, $urandom, $urandom);
                    else
                        push_op(MODE_BAR, $urandom, $urandom);
                end
            end
            else if (r < 50)
            begin
                n_steps = ($urandom_range(0, 9) == 0) ? MAX_CHAIN_STEPS : $urandom_range(1, 5);
                repeat ($urandom_range(1, 4))
                    push_bank_write($urandom_range(0, 15), $urandom_range(0, 7), $urandom);
                for (int i = 0; i < n_steps; i++)
                    push_step_write(i, $urandom_range(0, 15), $urandom_range(0, 3));
                push_chain(n_steps, $urandom_range(0, 1));
                repeat ($urandom_range(4, 24))
                begin
                    r = $urandom_range(0, 99);
                    if (r < 65)
                        push_op(MODE_BAR, $urandom, $urandom);
                    else if (r < 85)
                        push_op(MODE_QUERY, $urandom, $urandom);
                    else if (r < 91)
                        push_op(MODE_QUEUE, $urandom, $urandom);
                    else if (r < 94)
                        push_step_write($urandom_range(0, 15), $urandom_range(0, 15),
                                        $urandom_range(0, 3));
                    else if (r < 97)
                        push_op(MODE_START, $urandom, $urandom);
                    else
                        push_op(MODE_APPLY_NOW, $urandom, $urandom);
                end
            end
            else
            begin
                // Single noise word with every field random.
                r = $urandom_range(0, 99);
                if (r < 12)
                    words_to_send.push_back(rand_word(MODE_WRITE_BANK));
                else if (r < 22)
                    words_to_send.push_back(rand_word(MODE_WRITE_STEP));
                else if (r < 28)
                    words_to_send.push_back(rand_word(MODE_SET_CHAIN));
                else if (r < 36)
                    words_to_send.push_back(rand_word(MODE_QUEUE));
                else if (r < 42)
                    words_to_send.push_back(rand_word(MODE_APPLY_NOW));
                else if (r < 47)
                    words_to_send.push_back(rand_word(MODE_START));
                else if (r < 77)
                    words_to_send.push_back(rand_word(MODE_BAR));
                else
                    words_to_send.push_back(rand_word(MODE_QUERY));
            end
        end
        words_total = words_to_send.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while ((words_accepted < words_total || scene_results_due.size() > 0)
               && idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
        end

        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_bar_synced_scene_chain_sequencer NOT OK");
        end
        else
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (scene_results_due.size() > 0)
            begin
                $display("%0t: %0d result words expected, actual none", $time,
                         scene_results_due.size());
                mismatches++;
            end
            if (mismatches == 0)
            begin
                $display("tb_bar_synced_scene_chain_sequencer OK");
            end
            else
            begin
                $display("tb_bar_synced_scene_chain_sequencer NOT OK");
            end
        end
        $finish;
    end

endmodule
